// File: hw/rtl/bpq_pkg.sv
// Package for the bounded priority queue.
// Holds operation and status codes, field widths and the default capacity.
// No dependencies.
package bpq_pkg;

	localparam int unsigned DEPTH_DEF = 8;

	localparam int unsigned OP_W      = 2;
	localparam int unsigned DATA_W    = 32;
	localparam int unsigned PRIO_W    = 4;
	localparam int unsigned STS_W     = 2;
	localparam int unsigned CNT_OUT_W = 4;

	localparam logic [OP_W-1:0] OP_ENQ   = 2'd0;
	localparam logic [OP_W-1:0] OP_DEQ   = 2'd1;
	localparam logic [OP_W-1:0] OP_PEEK  = 2'd2;
	localparam logic [OP_W-1:0] OP_CLEAR = 2'd3;

	localparam logic [STS_W-1:0] STS_OK    = 2'd0;
	localparam logic [STS_W-1:0] STS_FULL  = 2'd1;
	localparam logic [STS_W-1:0] STS_EMPTY = 2'd2;

endpackage

// File: hw/rtl/bpq_if.sv
// Channel interfaces for the bounded priority queue: request and response.
// Depends on bpq_pkg for the field widths.
interface bpq_req_if import bpq_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic [OP_W-1:0]          opcode;
	logic signed [DATA_W-1:0] data_in;
	logic [PRIO_W-1:0]        prio_in;

	modport source (output valid, opcode, data_in, prio_in, input ready);
	modport sink (input valid, opcode, data_in, prio_in, output ready);
endinterface

interface bpq_rsp_if import bpq_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic [STS_W-1:0]         status;
	logic signed [DATA_W-1:0] data_out;
	logic [CNT_OUT_W-1:0]     count_out;

	modport source (output valid, status, data_out, count_out, input ready);
	modport sink (input valid, status, data_out, count_out, output ready);
endinterface

// File: hw/rtl/bpq_ram.sv
// Generic simple dual-port RAM: one write port and one registered read port.
// No dependencies.
module bpq_ram #(
	parameter int unsigned WIDTH = 36,
	parameter int unsigned DEPTH = 8
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// File: hw/rtl/bounded_priority_queue_top.sv
// Top level of the bounded priority queue, with entries held in one RAM.
// Depends on bpq_pkg, the bpq_req_if and bpq_rsp_if interfaces and bpq_ram.
//
// The queue holds up to DEPTH entries in arrival order in a single RAM with a
// registered read port, and works on one item at a time. Each result goes to a
// pending register when its work ends and moves to the output register when
// that register is empty or its result is taken. The input stays closed while
// a result waits in the pending register. A dequeue scans the held entries in
// the RAM, one read per cycle, for the one of highest priority. It then moves
// each younger entry down one place, one read and one write per cycle. While
// the output register holds a result that has not been taken, one more item is
// taken and its result waits in the pending register.
module bounded_priority_queue_top import bpq_pkg::*; #(
	parameter int unsigned DEPTH = DEPTH_DEF
) (
	input logic       clk,
	input logic       arst_n,
	bpq_req_if.sink   req,
	bpq_rsp_if.source rsp
);

	localparam int unsigned AW  = $clog2(DEPTH);
	localparam int unsigned CW  = $clog2(DEPTH + 1);
	localparam int unsigned EW  = DATA_W + PRIO_W;
	localparam int unsigned CXW = (CW > CNT_OUT_W) ? CW : CNT_OUT_W;

	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_PEEK  = 2'd1;
	localparam logic [1:0] S_SCAN  = 2'd2;
	localparam logic [1:0] S_SHIFT = 2'd3;

	logic [1:0]        state_q;
	logic [CW-1:0]     count_q;
	logic [CW-1:0]     rd_ptr_q;
	logic              rv_q;
	logic [AW-1:0]     ridx_q;
	logic [AW-1:0]     best_idx_q;
	logic [PRIO_W-1:0] best_prio_q;
	logic [DATA_W-1:0] best_val_q;

	logic              p_v_q;
	logic [STS_W-1:0]  p_status_q;
	logic [DATA_W-1:0] p_data_q;
	logic [CW-1:0]     p_count_q;
	logic              o_v_q;
	logic [STS_W-1:0]  o_status_q;
	logic [DATA_W-1:0] o_data_q;
	logic [CW-1:0]     o_count_q;

	logic              wr_en;
	logic [AW-1:0]     wr_addr;
	logic [EW-1:0]     wr_data;
	logic              rd_en;
	logic [AW-1:0]     rd_addr;
	logic [EW-1:0]     rd_data;

	logic              accept;
	logic              out_free;
	logic              scan_end;
	logic              take;
	logic [PRIO_W-1:0] rd_prio;
	logic              res_load;
	logic [STS_W-1:0]  res_status;
	logic [DATA_W-1:0] res_data;
	logic [CW-1:0]     res_count;
	logic [CXW-1:0]    count_x;

	bpq_ram #(
		.WIDTH (EW),
		.DEPTH (DEPTH)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	assign accept   = req.valid && req.ready;
	assign out_free = !o_v_q || rsp.ready;
	assign scan_end = (rd_ptr_q == count_q) && !rv_q;
	assign rd_prio  = rd_data[EW-1:DATA_W];
	assign take     = rv_q && ((ridx_q == '0) || (rd_prio > best_prio_q));

	always_comb begin
		wr_en      = 1'b0;
		wr_addr    = '0;
		wr_data    = {req.prio_in, req.data_in};
		rd_en      = 1'b0;
		rd_addr    = '0;
		res_load   = 1'b0;
		res_status = STS_OK;
		res_data   = '0;
		res_count  = count_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					case (req.opcode)
						OP_ENQ: begin
							res_load = 1'b1;
							if (count_q >= CW'(DEPTH)) begin
								res_status = STS_FULL;
							end else begin
								wr_en     = 1'b1;
								wr_addr   = count_q[AW-1:0];
								res_count = count_q + 1'b1;
							end
						end
						OP_DEQ: begin
							if (count_q == '0) begin
								res_load   = 1'b1;
								res_status = STS_EMPTY;
							end
						end
						OP_PEEK: begin
							if (count_q == '0) begin
								res_load   = 1'b1;
								res_status = STS_EMPTY;
							end else begin
								rd_en = 1'b1;
							end
						end
						default: begin
							res_load  = 1'b1;
							res_count = '0;
						end
					endcase
				end
			end
			S_PEEK: begin
				res_load = 1'b1;
				res_data = rd_data[DATA_W-1:0];
			end
			S_SCAN: begin
				if (rd_ptr_q < count_q) begin
					rd_en   = 1'b1;
					rd_addr = rd_ptr_q[AW-1:0];
				end
			end
			S_SHIFT: begin
				if (rd_ptr_q < count_q) begin
					rd_en   = 1'b1;
					rd_addr = rd_ptr_q[AW-1:0];
				end
				if (rv_q) begin
					wr_en   = 1'b1;
					wr_addr = ridx_q - 1'b1;
					wr_data = rd_data;
				end
				if (scan_end) begin
					res_load  = 1'b1;
					res_data  = best_val_q;
					res_count = count_q - 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			count_q  <= '0;
			rd_ptr_q <= '0;
			rv_q     <= 1'b0;
			p_v_q    <= 1'b0;
			o_v_q    <= 1'b0;
		end else begin
			rv_q <= rd_en;
			if (rd_en) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (res_load) begin
				count_q <= res_count;
			end
			case (state_q)
				S_IDLE: begin
					if (accept && (count_q != '0)) begin
						if (req.opcode == OP_DEQ) begin
							state_q  <= S_SCAN;
							rd_ptr_q <= '0;
						end else if (req.opcode == OP_PEEK) begin
							state_q <= S_PEEK;
						end
					end
				end
				S_PEEK: begin
					state_q <= S_IDLE;
				end
				S_SCAN: begin
					if (scan_end) begin
						state_q  <= S_SHIFT;
						rd_ptr_q <= CW'(best_idx_q) + 1'b1;
					end
				end
				S_SHIFT: begin
					if (scan_end) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			p_v_q <= res_load || (p_v_q && !out_free);
			if (p_v_q && out_free) begin
				o_v_q <= 1'b1;
			end else if (rsp.ready) begin
				o_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		ridx_q <= rd_addr;
		if ((state_q == S_SCAN) && take) begin
			best_idx_q  <= ridx_q;
			best_prio_q <= rd_prio;
			best_val_q  <= rd_data[DATA_W-1:0];
		end
		if (res_load) begin
			p_status_q <= res_status;
			p_data_q   <= res_data;
			p_count_q  <= res_count;
		end
		if (p_v_q && out_free) begin
			o_status_q <= p_status_q;
			o_data_q   <= p_data_q;
			o_count_q  <= p_count_q;
		end
	end

	assign count_x = CXW'(o_count_q);

	assign req.ready     = (state_q == S_IDLE) && !p_v_q;
	assign rsp.valid     = o_v_q;
	assign rsp.status    = o_status_q;
	assign rsp.data_out  = o_data_q;
	assign rsp.count_out = count_x[CNT_OUT_W-1:0];

endmodule
